@@ rtl/lssa_pkg.sv @@
// shared types, codes and helpers for the slot allocator
package lssa_pkg;

    // slots per bitmap word and the width of a bit position inside a word
    localparam int WORD_BITS = 32;
    localparam int WBIT_W    = 5;

    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_READ  = 2'd2,
        ACT_WRITE = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_RANGE       = 3'd1,
        ST_NOT_STARTED = 3'd2,
        ST_NOT_USED    = 3'd3,
        ST_FULL        = 3'd4
    } t_status;

    // read and write strobes of one memory
    typedef struct packed {
        logic rd;
        logic wr;
    } t_mem_op;

    // position of the lowest clear bit of a bitmap word
    function automatic logic [WBIT_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] bits);
        logic [WBIT_W-1:0] pos;
        pos = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!bits[b]) begin
                pos = WBIT_W'(b);
            end
        end
        return pos;
    endfunction

endpackage

@@ rtl/local_storage_slot_allocator_top.sv @@
// top level of the slot allocator: request sequencer, counters and result register
//
// Slot allocator with SLOTS slots. Each request is allocate, free, read or write and
// gives exactly one result. A request passes through accept, a read of the bitmap
// word and value memories, a modify and write-back step, and the load of the result
// register; one request is in flight at a time, set by the read-modify-write of the
// bitmap memory. The next request is accepted as soon as the previous result sits in
// the output register, even if it is not yet taken. Allocate searches the per-word full
// flags for the lowest word with a free slot and then the word itself. Bitmap words
// carry valid bits, so no clearing pass is needed after reset; slot values that were
// never written read as zero. At most SLOTS-1 slots can be in use at once.
module local_storage_slot_allocator_top #(
    parameter int SLOTS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_index,
    input  logic [63:0] i_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [9:0]  o_slot,
    output logic [63:0] o_data
);
    import lssa_pkg::*;

    localparam int NWORDS = (SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int WADR_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = SLOT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_MOD,
        S_HOLD
    } t_state;

    t_state              r_state, n_state;
    t_action             r_action;
    logic [15:0]         r_index;
    logic [63:0]         r_value;
    logic [WADR_W-1:0]   r_wadr, n_wadr;
    logic                r_started, n_started;
    logic [CNT_W-1:0]    r_count, n_count;
    t_status             r_res_status, n_res_status;
    logic [9:0]          r_res_slot, n_res_slot;
    logic [63:0]         r_res_data, n_res_data;
    logic                r_out_valid, n_out_valid;
    logic [2:0]          r_o_status;
    logic [9:0]          r_o_slot;
    logic [63:0]         r_o_data;

    t_mem_op                bm_op, val_op;
    logic [WADR_W-1:0]      bm_rd_adr;
    logic [2*WORD_BITS-1:0] bm_rd_data, bm_wr_data;
    logic [WADR_W-1:0]      free_word;
    logic [63:0]            val_rd_data;

    logic [WORD_BITS-1:0]   used, wrt, onehot;
    logic [WBIT_W-1:0]      bit_sel;
    logic                   in_range;
    logic                   accept_in, load_out;

    lssa_bitmap #(
        .NWORDS (NWORDS),
        .WADR_W (WADR_W)
    ) u_bitmap (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (bm_op),
        .i_rd_adr    (bm_rd_adr),
        .i_wr_adr    (r_wadr),
        .i_wr_data   (bm_wr_data),
        .o_rd_data   (bm_rd_data),
        .o_free_word (free_word)
    );

    lssa_values #(
        .SLOTS (SLOTS),
        .ADR_W (SLOT_W)
    ) u_values (
        .i_clk     (i_clk),
        .i_op      (val_op),
        .i_adr     (r_index[SLOT_W-1:0]),
        .i_wr_data (r_value),
        .o_rd_data (val_rd_data)
    );

    assign accept_in = i_in_valid && (r_state == S_IDLE);
    assign load_out  = (r_state == S_HOLD) && (!r_out_valid || i_out_ready);

    // bitmap word address: lowest non-full word for allocate, else the word of the index
    assign bm_rd_adr = (r_action == ACT_ALLOC) ? free_word : r_index[WBIT_W +: WADR_W];

    // fields of the fetched bitmap word
    assign used     = bm_rd_data[WORD_BITS-1:0];
    assign wrt      = bm_rd_data[2*WORD_BITS-1:WORD_BITS];
    assign bit_sel  = (r_action == ACT_ALLOC) ? lowest_zero(used) : r_index[WBIT_W-1:0];
    assign onehot   = WORD_BITS'(1) << bit_sel;
    assign in_range = r_index < 16'(SLOTS);

    // sequencing and modify step
    always_comb begin
        n_state      = r_state;
        n_wadr       = r_wadr;
        n_started    = r_started;
        n_count      = r_count;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_res_data   = r_res_data;
        n_out_valid  = r_out_valid;
        bm_op        = '0;
        val_op       = '0;
        bm_wr_data   = bm_rd_data;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept_in) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                bm_op.rd = 1'b1;
                val_op.rd = 1'b1;
                n_wadr   = bm_rd_adr;
                n_state  = S_MOD;
            end
            S_MOD: begin
                n_res_status = ST_OK;
                n_res_slot   = '0;
                n_res_data   = '0;
                n_state      = S_HOLD;
                if (r_action == ACT_ALLOC) begin
                    n_started = 1'b1;
                    if (r_count >= CNT_W'(SLOTS - 1)) begin
                        n_res_status = ST_FULL;
                    end else begin
                        bm_wr_data = {wrt, used | onehot};
                        bm_op.wr   = 1'b1;
                        n_count    = r_count + CNT_W'(1);
                        n_res_slot = 10'((32'(r_wadr) << WBIT_W) | 32'(bit_sel));
                    end
                end else if (!in_range) begin
                    n_res_status = ST_RANGE;
                end else if (!r_started) begin
                    n_res_status = ST_NOT_STARTED;
                end else if (r_action == ACT_FREE) begin
                    // freeing an unused slot is accepted and changes nothing
                    if (used[bit_sel]) begin
                        bm_wr_data = {wrt, used & ~onehot};
                        bm_op.wr   = 1'b1;
                        n_count    = r_count - CNT_W'(1);
                    end
                end else if (!used[bit_sel]) begin
                    n_res_status = ST_NOT_USED;
                end else if (r_action == ACT_READ) begin
                    n_res_data = wrt[bit_sel] ? val_rd_data : '0;
                end else begin
                    val_op.wr  = 1'b1;
                    bm_wr_data = {wrt | onehot, used};
                    bm_op.wr   = 1'b1;
                end
            end
            S_HOLD: begin
                if (load_out) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state, counters and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_started   <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_o_status  <= '0;
            r_o_slot    <= '0;
            r_o_data    <= '0;
        end else begin
            r_state     <= n_state;
            r_started   <= n_started;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (load_out) begin
                r_o_status <= r_res_status;
                r_o_slot   <= r_res_slot;
                r_o_data   <= r_res_data;
            end
        end
    end

    // request capture and result
    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_action <= t_action'(i_action);
            r_index  <= i_index;
            r_value  <= i_value;
        end
        r_wadr       <= n_wadr;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_res_data   <= n_res_data;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_o_status;
    assign o_slot      = r_o_slot;
    assign o_data      = r_o_data;

endmodule

@@ rtl/lssa_bitmap.sv @@
// bitmap word memory with word valid bits, full flags and free word search
module lssa_bitmap #(
    parameter int NWORDS = 32,
    parameter int WADR_W = 5
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lssa_pkg::t_mem_op                 i_op,
    input  logic [WADR_W-1:0]                 i_rd_adr,
    input  logic [WADR_W-1:0]                 i_wr_adr,
    input  logic [2*lssa_pkg::WORD_BITS-1:0]  i_wr_data,
    output logic [2*lssa_pkg::WORD_BITS-1:0]  o_rd_data,
    output logic [WADR_W-1:0]                 o_free_word
);
    import lssa_pkg::*;

    // each word: upper half marks slots ever written, lower half marks slots in use
    logic [2*WORD_BITS-1:0] mem [NWORDS];
    logic [2*WORD_BITS-1:0] r_rd_data;
    logic                   r_rd_vld;
    logic [NWORDS-1:0]      r_word_vld;
    logic [NWORDS-1:0]      r_full;

    // word storage, registered read
    always_ff @(posedge i_clk) begin
        if (i_op.wr) begin
            mem[i_wr_adr] <= i_wr_data;
        end
        if (i_op.rd) begin
            r_rd_data <= mem[i_rd_adr];
        end
    end

    // words never written read as zero; full flag follows the used half
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_vld <= '0;
            r_full     <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            if (i_op.wr) begin
                r_word_vld[i_wr_adr] <= 1'b1;
                r_full[i_wr_adr]     <= &i_wr_data[WORD_BITS-1:0];
            end
            if (i_op.rd) begin
                r_rd_vld <= r_word_vld[i_rd_adr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

    // lowest word that still has a free slot
    always_comb begin
        o_free_word = '0;
        for (int w = NWORDS - 1; w >= 0; w--) begin
            if (!r_full[w]) begin
                o_free_word = WADR_W'(w);
            end
        end
    end

endmodule

@@ rtl/lssa_values.sv @@
// value memory, one 64-bit word per slot, registered read
module lssa_values #(
    parameter int SLOTS  = 1024,
    parameter int ADR_W  = 10
) (
    input  logic              i_clk,
    input  lssa_pkg::t_mem_op i_op,
    input  logic [ADR_W-1:0]  i_adr,
    input  logic [63:0]       i_wr_data,
    output logic [63:0]       o_rd_data
);
    import lssa_pkg::*;

    logic [63:0] mem [SLOTS];
    logic [63:0] r_rd_data;

    // single port storage
    always_ff @(posedge i_clk) begin
        if (i_op.wr) begin
            mem[i_adr] <= i_wr_data;
        end
        if (i_op.rd) begin
            r_rd_data <= mem[i_adr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
